/* sv/bvt_pkg.sv */
// Package for the bounding volume pair test: widths, test codes and the
// pipeline control bundle. No dependencies; used by all files but bvt_rsp_if.
package bvt_pkg;

   // port field widths
   localparam int TYPE_W   = 3;
   localparam int CENTER_W = 32;
   localparam int EXTENT_W = 31;

   // coordinate width used by the datapath (8..32); low bits of each field
   localparam int COORD_BITS = 32;
   localparam int EXT_BITS   = COORD_BITS - 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SUM_W      = SQ_W + 1;

   // register stages from input to the response register
   localparam int NUM_STAGES = 6;

   typedef enum logic [TYPE_W-1:0] {
      TEST_BOX_OVERLAP        = 3'd0,
      TEST_CIRCLE_OVERLAP     = 3'd1,
      TEST_BOX_CIRCLE_OVERLAP = 3'd2,
      TEST_BOX_CONTAIN        = 3'd3,
      TEST_CIRCLE_CONTAIN     = 3'd4,
      TEST_BOX_HOLDS_CIRCLE   = 3'd5,
      TEST_CIRCLE_HOLDS_BOX   = 3'd6
   } test_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] advance;
   } pipe_ctrl_type;

endpackage

/* sv/bvt_req_if.sv */
// Request channel: valid/ready handshake carrying one pair test.
// Depends on bvt_pkg for field widths.
interface bvt_req_if;
   logic                          valid;
   logic                          ready;
   logic [bvt_pkg::TYPE_W-1:0]    req_type;
   logic [bvt_pkg::CENTER_W-1:0]  a_center_x;
   logic [bvt_pkg::CENTER_W-1:0]  a_center_y;
   logic [bvt_pkg::EXTENT_W-1:0]  a_extent_x;
   logic [bvt_pkg::EXTENT_W-1:0]  a_extent_y;
   logic [bvt_pkg::CENTER_W-1:0]  b_center_x;
   logic [bvt_pkg::CENTER_W-1:0]  b_center_y;
   logic [bvt_pkg::EXTENT_W-1:0]  b_extent_x;
   logic [bvt_pkg::EXTENT_W-1:0]  b_extent_y;

   modport source (
      output valid, req_type, a_center_x, a_center_y, a_extent_x, a_extent_y,
             b_center_x, b_center_y, b_extent_x, b_extent_y,
      input  ready
   );
   modport sink (
      input  valid, req_type, a_center_x, a_center_y, a_extent_x, a_extent_y,
             b_center_x, b_center_y, b_extent_x, b_extent_y,
      output ready
   );
endinterface

/* sv/bvt_rsp_if.sv */
// Response channel: valid/ready handshake carrying the hit bit.
// No dependencies.
interface bvt_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

/* sv/bvt_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the test pipeline.
// Depends on bvt_pkg; a stage loads when it is empty or the next one loads.
module bvt_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_ready,
   output bvt_pkg::pipe_ctrl_type ctrl
);

   logic [bvt_pkg::NUM_STAGES-1:0] valid_ff;
   logic [bvt_pkg::NUM_STAGES-1:0] valid_in;
   logic [bvt_pkg::NUM_STAGES-1:0] advance;

   // ripple the load enables back from the response register
   always_comb begin
      advance[bvt_pkg::NUM_STAGES-1] = !valid_ff[bvt_pkg::NUM_STAGES-1] || out_ready;
      for (int k = bvt_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   // move valid bits along with the data
   always_comb begin
      valid_in[0] = advance[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < bvt_pkg::NUM_STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.valid   = valid_ff;
   assign ctrl.advance = advance;

   // a stalled stage keeps its transaction
   for (genvar g = 0; g < bvt_pkg::NUM_STAGES; g++) begin : g_hold
      a_hold: assert property (@(posedge clock) disable iff (reset)
         valid_ff[g] && !advance[g] |=> valid_ff[g])
         else $error("stalled stage %0d dropped its transaction", g);
   end

   // an accepted request lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && advance[0] |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // a full pipeline with a stalled output refuses requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !out_ready |-> !advance[0])
      else $error("full pipeline accepted a request while stalled");

endmodule

/* sv/bounding_volume_test.sv */
// Bounding volume pair test: box/circle overlap and containment, one hit bit.
// Pipeline: 6 register stages, stage 0 through the response register in stage 5.
// Throughput: one transaction per cycle unless the response is stalled; stage 3 holds three squarers.
// Back pressure stalls only full stages, so bubbles are squeezed out.
// Reset (synchronous, active high) empties all six stages; no other state.
module bounding_volume_test (
   input  logic         clock,
   input  logic         reset,
   bvt_req_if.sink      req_if,
   bvt_rsp_if.source    rsp_if
);

   localparam int CB = bvt_pkg::COORD_BITS;
   localparam int EB = bvt_pkg::EXT_BITS;

   bvt_pkg::pipe_ctrl_type ctrl;

   bvt_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .ctrl      (ctrl)
   );

   assign req_if.ready = ctrl.advance[0];

   // ---------------------------------------------------------------- stage 0
   // take low coordinate bits, form signed center differences
   logic [CB-1:0]          ax, ay, bx, by;
   logic [CB:0]            ddx0_in, ddy0_in;
   logic [CB:0]            ddx0_ff, ddy0_ff;
   bvt_pkg::test_type      sel0_ff;
   logic [EB-1:0]          aex0_ff, aey0_ff, bex0_ff, bey0_ff;

   assign ax      = req_if.a_center_x[CB-1:0];
   assign ay      = req_if.a_center_y[CB-1:0];
   assign bx      = req_if.b_center_x[CB-1:0];
   assign by      = req_if.b_center_y[CB-1:0];
   assign ddx0_in = {ax[CB-1], ax} - {bx[CB-1], bx};
   assign ddy0_in = {ay[CB-1], ay} - {by[CB-1], by};

   always_ff @(posedge clock) begin
      if (ctrl.advance[0]) begin
         sel0_ff <= bvt_pkg::test_type'(req_if.req_type);
         ddx0_ff <= ddx0_in;
         ddy0_ff <= ddy0_in;
         aex0_ff <= req_if.a_extent_x[EB-1:0];
         aey0_ff <= req_if.a_extent_y[EB-1:0];
         bex0_ff <= req_if.b_extent_x[EB-1:0];
         bey0_ff <= req_if.b_extent_y[EB-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 1
   // absolute distances, extent sums and differences
   logic [CB:0]            ndx, ndy;
   logic [CB-1:0]          dx1_in, dy1_in, sumx1_in, sumy1_in;
   logic [EB-1:0]          difx1_in, dify1_in, rd1_in;
   logic                   xgt1_in, ygt1_in;
   logic [CB-1:0]          dx1_ff, dy1_ff, sumx1_ff, sumy1_ff;
   logic [EB-1:0]          difx1_ff, dify1_ff, rd1_ff;
   logic                   xgt1_ff, ygt1_ff;
   bvt_pkg::test_type      sel1_ff;
   logic [EB-1:0]          aex1_ff, aey1_ff, bex1_ff, bey1_ff;

   always_comb begin
      ndx      = ~ddx0_ff + 1'b1;
      ndy      = ~ddy0_ff + 1'b1;
      dx1_in   = ddx0_ff[CB] ? ndx[CB-1:0] : ddx0_ff[CB-1:0];
      dy1_in   = ddy0_ff[CB] ? ndy[CB-1:0] : ddy0_ff[CB-1:0];
      sumx1_in = {1'b0, aex0_ff} + {1'b0, bex0_ff};
      sumy1_in = {1'b0, aey0_ff} + {1'b0, bey0_ff};
      xgt1_in  = aex0_ff > bex0_ff;
      ygt1_in  = aey0_ff > bey0_ff;
      difx1_in = aex0_ff - bex0_ff;
      dify1_in = aey0_ff - bey0_ff;
      rd1_in   = xgt1_in ? difx1_in : (bex0_ff - aex0_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance[1]) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         sumx1_ff <= sumx1_in;
         sumy1_ff <= sumy1_in;
         difx1_ff <= difx1_in;
         dify1_ff <= dify1_in;
         rd1_ff   <= rd1_in;
         xgt1_ff  <= xgt1_in;
         ygt1_ff  <= ygt1_in;
         sel1_ff  <= sel0_ff;
         aex1_ff  <= aex0_ff;
         aey1_ff  <= aey0_ff;
         bex1_ff  <= bex0_ff;
         bey1_ff  <= bey0_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // linear tests, clamp gaps and squarer operand selection
   logic [CB:0]            hbx, hby, hax, hay, cby;
   logic [CB-1:0]          gx, gy;
   logic                   lin2_in, quad2_in;
   logic [CB-1:0]          mx2_in, my2_in, mr2_in;
   logic                   lin2_ff, quad2_ff;
   logic [CB-1:0]          mx2_ff, my2_ff, mr2_ff;
   bvt_pkg::test_type      sel2_ff;

   always_comb begin
      hbx = {1'b0, dx1_ff} + {2'b0, bex1_ff};
      hby = {1'b0, dy1_ff} + {2'b0, bex1_ff};
      cby = {1'b0, dy1_ff} + {2'b0, bey1_ff};
      hax = {2'b0, aex1_ff};
      hay = {2'b0, aey1_ff};
      gx  = (dx1_ff > {1'b0, aex1_ff}) ? dx1_ff - {1'b0, aex1_ff} : '0;
      gy  = (dy1_ff > {1'b0, aey1_ff}) ? dy1_ff - {1'b0, aey1_ff} : '0;

      case (sel1_ff)
         bvt_pkg::TEST_BOX_OVERLAP: begin
            lin2_in = (dx1_ff < sumx1_ff) && (dy1_ff < sumy1_ff);
         end
         bvt_pkg::TEST_BOX_CONTAIN: begin
            lin2_in = xgt1_ff && ygt1_ff && (dx1_ff < {1'b0, difx1_ff})
                      && (dy1_ff < {1'b0, dify1_ff});
         end
         bvt_pkg::TEST_BOX_HOLDS_CIRCLE: begin
            lin2_in = (hbx < hax) && (hby < hay);
         end
         bvt_pkg::TEST_CIRCLE_HOLDS_BOX: begin
            lin2_in = (hbx < hax) && (cby < hax);
         end
         default: begin
            lin2_in = 1'b0;
         end
      endcase

      quad2_in = sel1_ff inside {bvt_pkg::TEST_CIRCLE_OVERLAP,
                                 bvt_pkg::TEST_BOX_CIRCLE_OVERLAP,
                                 bvt_pkg::TEST_CIRCLE_CONTAIN};

      mx2_in = dx1_ff;
      my2_in = dy1_ff;
      case (sel1_ff)
         bvt_pkg::TEST_CIRCLE_OVERLAP: begin
            mr2_in = sumx1_ff;
         end
         bvt_pkg::TEST_BOX_CIRCLE_OVERLAP: begin
            mx2_in = gx;
            my2_in = gy;
            mr2_in = {1'b0, bex1_ff};
         end
         bvt_pkg::TEST_CIRCLE_CONTAIN: begin
            mr2_in = {1'b0, rd1_ff};
         end
         default: begin
            mr2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance[2]) begin
         lin2_ff  <= lin2_in;
         quad2_ff <= quad2_in;
         mx2_ff   <= mx2_in;
         my2_ff   <= my2_in;
         mr2_ff   <= mr2_in;
         sel2_ff  <= sel1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // full-width squares
   logic [bvt_pkg::SQ_W-1:0] sqx3_in, sqy3_in, sqr3_in;
   logic [bvt_pkg::SQ_W-1:0] sqx3_ff, sqy3_ff, sqr3_ff;
   logic                     lin3_ff, quad3_ff;
   bvt_pkg::test_type        sel3_ff;

   assign sqx3_in = {{CB{1'b0}}, mx2_ff} * {{CB{1'b0}}, mx2_ff};
   assign sqy3_in = {{CB{1'b0}}, my2_ff} * {{CB{1'b0}}, my2_ff};
   assign sqr3_in = {{CB{1'b0}}, mr2_ff} * {{CB{1'b0}}, mr2_ff};

   always_ff @(posedge clock) begin
      if (ctrl.advance[3]) begin
         sqx3_ff  <= sqx3_in;
         sqy3_ff  <= sqy3_in;
         sqr3_ff  <= sqr3_in;
         lin3_ff  <= lin2_ff;
         quad3_ff <= quad2_ff;
         sel3_ff  <= sel2_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // squared distance
   logic [bvt_pkg::SUM_W-1:0] dist4_in;
   logic [bvt_pkg::SUM_W-1:0] dist4_ff;
   logic [bvt_pkg::SQ_W-1:0]  sqr4_ff;
   logic                      lin4_ff, quad4_ff;
   bvt_pkg::test_type         sel4_ff;

   assign dist4_in = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};

   always_ff @(posedge clock) begin
      if (ctrl.advance[4]) begin
         dist4_ff <= dist4_in;
         sqr4_ff  <= sqr3_ff;
         lin4_ff  <= lin3_ff;
         quad4_ff <= quad3_ff;
         sel4_ff  <= sel3_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // final compare into the response register
   logic hit5_in, hit5_ff;

   assign hit5_in = quad4_ff ? (dist4_ff < {1'b0, sqr4_ff}) : lin4_ff;

   always_ff @(posedge clock) begin
      if (ctrl.advance[5]) begin
         hit5_ff <= hit5_in;
      end
   end

   assign rsp_if.valid = ctrl.valid[5];
   assign rsp_if.hit   = hit5_ff;

   // the unused selector never reports a hit
   a_unused_sel: assert property (@(posedge clock) disable iff (reset)
      ctrl.valid[4] && ctrl.advance[5] && (sel4_ff > bvt_pkg::TEST_CIRCLE_HOLDS_BOX)
      |=> !hit5_ff)
      else $error("unused selector reported a hit");

   // a squared-distance test and a linear test never both apply
   a_quad_lin: assert property (@(posedge clock) disable iff (reset)
      ctrl.valid[2] |-> !(quad2_ff && lin2_ff))
      else $error("quadratic and linear paths both active");

   // an empty response register never blocks requests
   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("request stalled with no response pending");

endmodule
